[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the slot stager.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/rrs_pkg.sv]
// Types and constants shared by the transmit slot stager modules.
`timescale 1ns / 1ps

package rrs_pkg;

   localparam int unsigned MIN_FRAME   = 14;
   localparam int unsigned MASK_W      = 16;
   localparam int unsigned LEN_W       = 11;
   localparam int unsigned SLOT_W      = 4;
   localparam int unsigned SEQ_W       = 32;
   localparam int unsigned COUNT_W     = 5;
   localparam int unsigned CSR_DATA_W  = 11;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [COUNT_W-1:0] RESET_SLOTS_IN_USE  = 5'd16;
   localparam logic [LEN_W-1:0]   RESET_SLOT_CAPACITY = 11'd1536;

   typedef enum logic [0:0] {
      OP_SEND  = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NOT_READY  = 2'd1,
      ST_BAD_LENGTH = 2'd2,
      ST_NO_SLOT    = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BLOCK_READY   = 2'd0,
      CSR_SLOTS_IN_USE  = 2'd1,
      CSR_SLOT_CAPACITY = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic               block_ready;
      logic [COUNT_W-1:0] slots_in_use;
      logic [LEN_W-1:0]   slot_capacity;
   } cfg_type;

   typedef struct packed {
      op_type            operation;
      logic [LEN_W-1:0]  frame_length;
      logic [MASK_W-1:0] slot_free_mask;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [SLOT_W-1:0]  chosen_slot;
      logic [SEQ_W-1:0]   slot_sequence;
      logic [COUNT_W-1:0] pending_count;
      logic               flush_request;
   } rsp_type;

endpackage

[rtl/rrs_rr_pick.sv]
// Rotating priority encoder: first eligible slot at or after the start index, wrapping.
`timescale 1ns / 1ps

module rrs_rr_pick #(
   parameter int WIDTH = 16,
   localparam int IDX_W = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
   input  logic [WIDTH-1:0] elig,
   input  logic [IDX_W-1:0] start,
   output logic             found,
   output logic [IDX_W-1:0] slot
);

   logic             hi_found;
   logic [IDX_W-1:0] hi_slot;
   logic             lo_found;
   logic [IDX_W-1:0] lo_slot;

   // Scan from the top down so the lowest matching index wins in each half.
   always_comb begin
      hi_found = 1'b0;
      hi_slot  = '0;
      lo_found = 1'b0;
      lo_slot  = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (elig[i]) begin
            lo_found = 1'b1;
            lo_slot  = IDX_W'(i);
            if (IDX_W'(i) >= start) begin
               hi_found = 1'b1;
               hi_slot  = IDX_W'(i);
            end
         end
      end
      found = lo_found;
      slot  = hi_found ? hi_slot : lo_slot;
   end

endmodule

[rtl/rrs_alloc.sv]
// Allocation core: ring state, claim mask, batch count and per-slot sequence numbers.
`timescale 1ns / 1ps

module rrs_alloc #(
   parameter int SLOT_COUNT  = 16,
   parameter int BATCH_DEPTH = 8,
   parameter int MAX_FRAME   = 1518
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  rrs_pkg::req_type req,
   input  rrs_pkg::cfg_type cfg,
   output rrs_pkg::rsp_type rsp
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CW    = rrs_pkg::COUNT_W;
   localparam int LW    = rrs_pkg::LEN_W;

   logic [IDX_W-1:0]          next_slot_ff, next_slot_in;
   logic [SLOT_COUNT-1:0]     claimed_ff, claimed_in;
   logic [CW-1:0]             staged_ff, staged_in;
   logic [rrs_pkg::SEQ_W-1:0] seq_ff [SLOT_COUNT];
   logic                      seq_we;

   logic [CW-1:0]             ring_n;
   logic                      len_ok;
   logic                      is_send;
   logic [IDX_W-1:0]          start;
   logic                      pre_flush;
   logic [SLOT_COUNT-1:0]     claim_base;
   logic [CW-1:0]             count_base;
   logic [CW-1:0]             count_after;
   logic [SLOT_COUNT-1:0]     elig;
   logic                      pick_found;
   logic [IDX_W-1:0]          pick_slot;
   logic [CW-1:0]             slot_plus;
   logic [rrs_pkg::SEQ_W-1:0] seq_cur;

   // Ring size is capped at the number of slots that exist.
   assign ring_n = (cfg.slots_in_use > CW'(SLOT_COUNT)) ? CW'(SLOT_COUNT) : cfg.slots_in_use;

   assign len_ok = (req.frame_length >= LW'(rrs_pkg::MIN_FRAME))
                && (req.frame_length <= LW'(MAX_FRAME))
                && (req.frame_length <= cfg.slot_capacity);

   assign is_send = (req.operation == rrs_pkg::OP_SEND);

   // A pointer left beyond a shrunken ring restarts the search at slot zero.
   assign start = (CW'(next_slot_ff) < ring_n) ? next_slot_ff : '0;

   // A full batch is submitted before a valid send looks for a slot.
   assign pre_flush  = cfg.block_ready && is_send && len_ok
                    && (staged_ff >= CW'(BATCH_DEPTH));
   assign claim_base = pre_flush ? '0 : claimed_ff;
   assign count_base = pre_flush ? '0 : staged_ff;

   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         elig[i] = req.slot_free_mask[i] && !claim_base[i] && (CW'(i) < ring_n);
      end
   end

   rrs_rr_pick #(
      .WIDTH (SLOT_COUNT)
   ) u_pick (
      .elig  (elig),
      .start (start),
      .found (pick_found),
      .slot  (pick_slot)
   );

   assign slot_plus   = CW'(pick_slot) + CW'(1);
   assign count_after = count_base + CW'(1);
   assign seq_cur     = seq_ff[pick_slot];

   always_comb begin
      next_slot_in      = next_slot_ff;
      claimed_in        = claimed_ff;
      staged_in         = staged_ff;
      seq_we            = 1'b0;
      rsp.status        = rrs_pkg::ST_OK;
      rsp.chosen_slot   = '0;
      rsp.slot_sequence = '0;
      rsp.flush_request = 1'b0;
      if (!cfg.block_ready) begin
         rsp.status = rrs_pkg::ST_NOT_READY;
      end else if (!is_send) begin
         rsp.flush_request = (staged_ff != '0);
         claimed_in        = '0;
         staged_in         = '0;
      end else if (!len_ok) begin
         rsp.status = rrs_pkg::ST_BAD_LENGTH;
      end else begin
         claimed_in        = claim_base;
         staged_in         = count_base;
         rsp.flush_request = pre_flush;
         if (!pick_found) begin
            rsp.status = rrs_pkg::ST_NO_SLOT;
         end else begin
            seq_we            = 1'b1;
            rsp.chosen_slot   = rrs_pkg::SLOT_W'(pick_slot);
            rsp.slot_sequence = seq_cur;
            next_slot_in      = (slot_plus >= ring_n) ? '0 : IDX_W'(slot_plus);
            if (count_after >= CW'(BATCH_DEPTH)) begin
               rsp.flush_request = 1'b1;
               claimed_in        = '0;
               staged_in         = '0;
            end else begin
               claimed_in = claim_base | (SLOT_COUNT'(1) << pick_slot);
               staged_in  = count_after;
            end
         end
      end
      rsp.pending_count = staged_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_slot_ff <= '0;
         claimed_ff   <= '0;
         staged_ff    <= '0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            seq_ff[i] <= '0;
         end
      end else if (fire) begin
         next_slot_ff <= next_slot_in;
         claimed_ff   <= claimed_in;
         staged_ff    <= staged_in;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (seq_we && (pick_slot == IDX_W'(i))) begin
               seq_ff[i] <= seq_cur + rrs_pkg::SEQ_W'(1);
            end
         end
      end
   end

endmodule

[rtl/tx_slot_round_robin_stager.sv]
// Top level of the transmit slot stager: request register, allocation core, response register.
//
//   Channel   Ports                                   Moves
//   request   req_valid / req_ready, req_* fields     send or flush request
//   response  rsp_valid / rsp_ready, rsp_* fields     one response per request
//   csr       csr_we, csr_index, csr_wdata            register write, no wait
//
// One request per cycle is sustained while rsp_ready is high. An accepted request has
// its response loaded into the response register when it advances; the rotating slot
// search is combinational between the two registers; the state updates with that load.
// Reset is synchronous and clears the claims, the count, the pointer and all sequence
// numbers. A stalled response holds the request register, which holds req_ready low.
`timescale 1ns / 1ps

module tx_slot_round_robin_stager #(
   parameter int SLOT_COUNT  = 16,
   parameter int BATCH_DEPTH = 8,
   parameter int MAX_FRAME   = 1518
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [10:0] req_frame_length,
   input  logic [15:0] req_slot_free_mask,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_chosen_slot,
   output logic [31:0] rsp_slot_sequence,
   output logic [4:0]  rsp_pending_count,
   output logic        rsp_flush_request,

   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   logic             in_valid_ff, in_valid_in;
   rrs_pkg::req_type req_ff, req_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rrs_pkg::rsp_type rsp_ff;
   rrs_pkg::rsp_type core_rsp;
   rrs_pkg::cfg_type cfg_ff, cfg_in;
   logic             advance;

   // The held request moves on whenever the response register is empty or draining.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign req_in.operation      = rrs_pkg::op_type'(req_operation);
   assign req_in.frame_length   = req_frame_length;
   assign req_in.slot_free_mask = req_slot_free_mask;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Register writes; an index past the last register is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (rrs_pkg::csr_index_type'(csr_index))
            rrs_pkg::CSR_BLOCK_READY:   cfg_in.block_ready   = csr_wdata[0];
            rrs_pkg::CSR_SLOTS_IN_USE:  cfg_in.slots_in_use  = csr_wdata[rrs_pkg::COUNT_W-1:0];
            rrs_pkg::CSR_SLOT_CAPACITY: cfg_in.slot_capacity = csr_wdata[rrs_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   rrs_alloc #(
      .SLOT_COUNT  (SLOT_COUNT),
      .BATCH_DEPTH (BATCH_DEPTH),
      .MAX_FRAME   (MAX_FRAME)
   ) u_alloc (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (req_ff),
      .cfg   (cfg_ff),
      .rsp   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         cfg_ff.block_ready   <= 1'b0;
         cfg_ff.slots_in_use  <= rrs_pkg::RESET_SLOTS_IN_USE;
         cfg_ff.slot_capacity <= rrs_pkg::RESET_SLOT_CAPACITY;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_chosen_slot   = rsp_ff.chosen_slot;
   assign rsp_slot_sequence = rsp_ff.slot_sequence;
   assign rsp_pending_count = rsp_ff.pending_count;
   assign rsp_flush_request = rsp_ff.flush_request;

endmodule

[rtl/rrs_checker.sv]
// Port-level checker for the transmit slot stager, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rrs_checker #(
   parameter int BATCH_DEPTH = 8
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [3:0]  rsp_chosen_slot,
   input logic [31:0] rsp_slot_sequence,
   input logic [4:0]  rsp_pending_count,
   input logic        rsp_flush_request
);

   // A stalled response keeps its contents.
   `ASSERT_NEXT_CYCLE(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_chosen_slot) && $stable(rsp_slot_sequence) && $stable(rsp_pending_count) && $stable(rsp_flush_request), "response changed while stalled")

   // Only a successful send reports a slot and a sequence number.
   `ASSERT_SAME_CYCLE(a_no_slot_data, clock, reset, rsp_valid && (rsp_status != rrs_pkg::ST_OK), (rsp_chosen_slot == 4'd0) && (rsp_slot_sequence == 32'd0), "slot data on a failed request")

   // A submitted batch always leaves nothing pending.
   `ASSERT_SAME_CYCLE(a_flush_empties, clock, reset, rsp_valid && rsp_flush_request, rsp_pending_count == 5'd0, "entries pending after a flush")

   // The batch never stays at or above its depth after a request.
   `ASSERT_SAME_CYCLE(a_batch_bound, clock, reset, rsp_valid, rsp_pending_count < 5'(BATCH_DEPTH), "pending count reached batch depth")

   // Refused requests change nothing, so they never submit a batch.
   `ASSERT_SAME_CYCLE(a_refused_no_flush, clock, reset, rsp_valid && ((rsp_status == rrs_pkg::ST_NOT_READY) || (rsp_status == rrs_pkg::ST_BAD_LENGTH)), !rsp_flush_request, "flush on a refused request")

endmodule

bind tx_slot_round_robin_stager rrs_checker #(
   .BATCH_DEPTH (BATCH_DEPTH)
) u_rrs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_chosen_slot   (rsp_chosen_slot),
   .rsp_slot_sequence (rsp_slot_sequence),
   .rsp_pending_count (rsp_pending_count),
   .rsp_flush_request (rsp_flush_request)
);

[tb/tb_tx_slot_round_robin_stager.sv]
// Self-checking testbench for the transmit slot stager: a directed table, then random traffic.
`timescale 1ns / 1ps

module tb_tx_slot_round_robin_stager;

   // These match the defaults of the block, and the instance is built with them.
   localparam int SLOT_COUNT  = 16;
   localparam int BATCH_DEPTH = 8;
   localparam int MAX_FRAME   = 1518;

   // The run ends if this many cycles pass with no handshake on either channel.
   localparam int STALL_LIMIT = 4000;

   typedef enum logic {
      ROW_CSR,
      ROW_REQ
   } row_kind_type;

   // One row of the directed table. It is either a register write or a request.
   // A request row may carry a typed-in response that replaces the prediction.
   typedef struct packed {
      row_kind_type           kind;
      rrs_pkg::csr_index_type csr_idx;
      logic [10:0]            csr_data;
      logic                   op;
      logic [10:0]            len;
      logic [15:0]            mask;
      logic                   typed;
      rrs_pkg::rsp_type       answer;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_operation;
   logic [10:0] req_frame_length;
   logic [15:0] req_slot_free_mask;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_chosen_slot;
   logic [31:0] rsp_slot_sequence;
   logic [4:0]  rsp_pending_count;
   logic        rsp_flush_request;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [10:0] csr_wdata;

   // Shadow copy of the block: its registers and its allocation state.
   rrs_pkg::cfg_type cfg;
   logic [3:0]       ring_ptr;
   logic [15:0]      claimed;
   logic [4:0]       staged;
   logic [31:0]      seq_no [16];

   // Responses owed by the block, oldest first.
   rrs_pkg::rsp_type grant_q [$];
   rrs_pkg::rsp_type next_grant;

   // The request on the wires, and its typed-in response if the table gives one.
   logic             cur_typed;
   rrs_pkg::rsp_type cur_answer;

   int          send_idle_pct;
   int          rsp_stall_pct;
   int          mismatch_count;
   int          quiet_cycles;

   tx_slot_round_robin_stager #(
      .SLOT_COUNT  (SLOT_COUNT),
      .BATCH_DEPTH (BATCH_DEPTH),
      .MAX_FRAME   (MAX_FRAME)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_frame_length   (req_frame_length),
      .req_slot_free_mask (req_slot_free_mask),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_chosen_slot    (rsp_chosen_slot),
      .rsp_slot_sequence  (rsp_slot_sequence),
      .rsp_pending_count  (rsp_pending_count),
      .rsp_flush_request  (rsp_flush_request),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Works out the response to one accepted request and moves the shadow state on.
   // A request is refused while the layout is unknown; a flush clears the claims and
   // the count; a send with a sane length searches the ring from the pointer for a
   // slot that the partner reports free and that no staged entry holds.
   function automatic rrs_pkg::rsp_type allocate_slot(logic op, logic [10:0] len,
                                                      logic [15:0] freem);
      rrs_pkg::rsp_type r;
      int unsigned      ring;
      int unsigned      slot;
      int unsigned      step;
      bit               found;
      r = '0;
      if (!cfg.block_ready) begin
         r.status = rrs_pkg::ST_NOT_READY;
      end else if (op == rrs_pkg::OP_FLUSH) begin
         // An empty flush is fine but does not count as a submission.
         r.flush_request = (staged != '0);
         claimed = '0;
         staged  = '0;
      end else if (len < rrs_pkg::MIN_FRAME || len > MAX_FRAME
                   || len > cfg.slot_capacity) begin
         r.status = rrs_pkg::ST_BAD_LENGTH;
      end else begin
         // A ring size above the slot count is clipped; a size of zero finds nothing.
         ring = (cfg.slots_in_use > SLOT_COUNT) ? SLOT_COUNT : cfg.slots_in_use;
         if (staged >= BATCH_DEPTH) begin
            r.flush_request = 1'b1;
            claimed = '0;
            staged  = '0;
         end
         // A pointer left beyond a shrunken ring restarts the search at slot zero.
         slot  = (ring_ptr < ring) ? ring_ptr : 0;
         found = 1'b0;
         for (step = 0; step < ring; step++) begin
            if (!found) begin
               if (!claimed[slot] && freem[slot]) begin
                  found = 1'b1;
               end else begin
                  slot++;
                  if (slot >= ring) slot = 0;
               end
            end
         end
         if (!found) begin
            // The claims, the count and the pointer stay as they are.
            r.status = rrs_pkg::ST_NO_SLOT;
         end else begin
            r.chosen_slot   = 4'(slot);
            r.slot_sequence = seq_no[slot];
            seq_no[slot]    = seq_no[slot] + 32'd1;
            claimed[slot]   = 1'b1;
            staged          = staged + 5'd1;
            ring_ptr        = (slot + 1 >= ring) ? 4'd0 : 4'(slot + 1);
            // Reaching the batch depth submits the batch at once.
            if (staged >= BATCH_DEPTH) begin
               r.flush_request = 1'b1;
               claimed = '0;
               staged  = '0;
            end
         end
      end
      r.pending_count = staged;
      return r;
   endfunction

   function automatic plan_row_type csr_row(rrs_pkg::csr_index_type idx, logic [10:0] data);
      plan_row_type row;
      row          = '0;
      row.kind     = ROW_CSR;
      row.csr_idx  = idx;
      row.csr_data = data;
      return row;
   endfunction

   function automatic plan_row_type req_row(logic op, logic [10:0] len, logic [15:0] mask);
      plan_row_type row;
      row      = '0;
      row.kind = ROW_REQ;
      row.op   = op;
      row.len  = len;
      row.mask = mask;
      return row;
   endfunction

   function automatic plan_row_type typed_row(logic op, logic [10:0] len, logic [15:0] mask,
                                              rrs_pkg::status_type st, logic [3:0] slot,
                                              logic [31:0] seq, logic [4:0] cnt, logic fl);
      plan_row_type row;
      row                      = req_row(op, len, mask);
      row.typed                = 1'b1;
      row.answer.status        = st;
      row.answer.chosen_slot   = slot;
      row.answer.slot_sequence = seq;
      row.answer.pending_count = cnt;
      row.answer.flush_request = fl;
      return row;
   endfunction

   task automatic compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Takes the oldest owed response and compares it with the one on the wires.
   task automatic check_grant();
      rrs_pkg::rsp_type want;
      if (grant_q.size() == 0) begin
         $display("%0t ns: response with none expected, expected nothing, got status %0d",
                  $time, rsp_status);
         mismatch_count++;
      end else begin
         want = grant_q.pop_front();
         compare_field("status", want.status, rsp_status);
         compare_field("chosen_slot", want.chosen_slot, rsp_chosen_slot);
         compare_field("slot_sequence", want.slot_sequence, rsp_slot_sequence);
         compare_field("pending_count", want.pending_count, rsp_pending_count);
         compare_field("flush_request", want.flush_request, rsp_flush_request);
      end
   endtask

   // All sampling happens here, at the rising edge, on the values from before the edge.
   // The order matters: a register write is applied first, then a response is checked,
   // and only then is a newly accepted request predicted and queued.
   always @(posedge clock) begin
      if (reset) begin
         cfg.block_ready   = 1'b0;
         cfg.slots_in_use  = rrs_pkg::RESET_SLOTS_IN_USE;
         cfg.slot_capacity = rrs_pkg::RESET_SLOT_CAPACITY;
         ring_ptr          = '0;
         claimed           = '0;
         staged            = '0;
         foreach (seq_no[s]) seq_no[s] = '0;
         quiet_cycles      = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               rrs_pkg::CSR_BLOCK_READY:   cfg.block_ready   = csr_wdata[0];
               rrs_pkg::CSR_SLOTS_IN_USE:  cfg.slots_in_use  = csr_wdata[4:0];
               rrs_pkg::CSR_SLOT_CAPACITY: cfg.slot_capacity = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) check_grant();
         if (req_valid && req_ready) begin
            next_grant = allocate_slot(req_operation, req_frame_length, req_slot_free_mask);
            // The predictor still runs on a typed row so that its state keeps step.
            if (cur_typed) next_grant = cur_answer;
            grant_q.push_back(next_grant);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // The receiver stalls at random, at the rate that the current phase sets.
   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Presents one request at a falling edge, with random idle cycles in front of it,
   // and holds it until it is accepted. It is entered and left just after a falling edge.
   task automatic push_request(logic op, logic [10:0] len, logic [15:0] mask,
                               logic typed, rrs_pkg::rsp_type answer);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid          = 1'b1;
      req_operation      = op;
      req_frame_length   = len;
      req_slot_free_mask = mask;
      cur_typed          = typed;
      cur_answer         = answer;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Registers change only while the block is idle: no request on the wires and
   // every owed response delivered, plus a short pause for the response register.
   task automatic write_csr(rrs_pkg::csr_index_type idx, logic [10:0] data);
      req_valid = 1'b0;
      while (grant_q.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   initial begin
      plan_row_type plan_q [$];
      plan_row_type row;
      int           k;
      int           phase;
      int           n_items;
      int           item;
      int           lim;
      bit           ready_cfg;
      int           slots_cfg;
      int           cap_cfg;
      logic         op;
      logic [10:0]  len;
      logic [15:0]  mask;

      req_valid          = 1'b0;
      req_operation      = rrs_pkg::OP_SEND;
      req_frame_length   = '0;
      req_slot_free_mask = '0;
      csr_we             = 1'b0;
      csr_index          = rrs_pkg::CSR_BLOCK_READY;
      csr_wdata          = '0;
      cur_typed          = 1'b0;
      cur_answer         = '0;
      send_idle_pct      = 0;
      rsp_stall_pct      = 0;
      mismatch_count     = 0;
      reset              = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Out of reset the layout is unknown, so a send and a flush are both refused.
      plan_q.push_back(typed_row(rrs_pkg::OP_SEND, 11'd64, 16'hFFFF,
                                 rrs_pkg::ST_NOT_READY, 0, 0, 0, 0));
      plan_q.push_back(typed_row(rrs_pkg::OP_FLUSH, 11'd0, 16'h0000,
                                 rrs_pkg::ST_NOT_READY, 0, 0, 0, 0));
      plan_q.push_back(csr_row(rrs_pkg::CSR_BLOCK_READY, 11'd1));
      // Lengths just below the minimum, just above the frame limit, and the largest.
      plan_q.push_back(typed_row(rrs_pkg::OP_SEND, 11'd13, 16'hFFFF,
                                 rrs_pkg::ST_BAD_LENGTH, 0, 0, 0, 0));
      plan_q.push_back(typed_row(rrs_pkg::OP_SEND, 11'd1519, 16'hFFFF,
                                 rrs_pkg::ST_BAD_LENGTH, 0, 0, 0, 0));
      plan_q.push_back(typed_row(rrs_pkg::OP_SEND, 11'd2047, 16'hFFFF,
                                 rrs_pkg::ST_BAD_LENGTH, 0, 0, 0, 0));
      // The shortest and the longest legal frames take the first two slots.
      plan_q.push_back(typed_row(rrs_pkg::OP_SEND, 11'd14, 16'hFFFF,
                                 rrs_pkg::ST_OK, 0, 0, 1, 0));
      plan_q.push_back(typed_row(rrs_pkg::OP_SEND, 11'd1518, 16'hFFFF,
                                 rrs_pkg::ST_OK, 1, 0, 2, 0));
      // Nothing free, then only slots that are already claimed here.
      plan_q.push_back(typed_row(rrs_pkg::OP_SEND, 11'd100, 16'h0000,
                                 rrs_pkg::ST_NO_SLOT, 0, 0, 2, 0));
      plan_q.push_back(typed_row(rrs_pkg::OP_SEND, 11'd100, 16'h0003,
                                 rrs_pkg::ST_NO_SLOT, 0, 0, 2, 0));
      // The last slot of the ring; the pointer wraps to zero behind it.
      plan_q.push_back(typed_row(rrs_pkg::OP_SEND, 11'd100, 16'h8000,
                                 rrs_pkg::ST_OK, 15, 0, 3, 0));
      // A flush with a batch staged, then one with nothing staged.
      plan_q.push_back(typed_row(rrs_pkg::OP_FLUSH, 11'd0, 16'h0000,
                                 rrs_pkg::ST_OK, 0, 0, 0, 1));
      plan_q.push_back(typed_row(rrs_pkg::OP_FLUSH, 11'd0, 16'h0000,
                                 rrs_pkg::ST_OK, 0, 0, 0, 0));
      // Slot zero again, now with its sequence number moved on.
      plan_q.push_back(typed_row(rrs_pkg::OP_SEND, 11'd100, 16'h0001,
                                 rrs_pkg::ST_OK, 0, 1, 1, 0));
      // Seven more sends fill the batch, and the last one submits it.
      for (k = 0; k < 7; k++) begin
         plan_q.push_back(req_row(rrs_pkg::OP_SEND, 11'(60 + k), 16'hFFFF));
      end
      // The smallest slot size that a frame can fit.
      plan_q.push_back(csr_row(rrs_pkg::CSR_SLOT_CAPACITY, 11'd14));
      plan_q.push_back(req_row(rrs_pkg::OP_SEND, 11'd15, 16'hFFFF));
      plan_q.push_back(req_row(rrs_pkg::OP_SEND, 11'd14, 16'hFFFF));
      plan_q.push_back(csr_row(rrs_pkg::CSR_SLOT_CAPACITY, 11'd2047));
      plan_q.push_back(req_row(rrs_pkg::OP_SEND, 11'd1518, 16'hFFFF));
      // A shrunken ring leaves the pointer stale, so the search restarts at zero.
      plan_q.push_back(csr_row(rrs_pkg::CSR_SLOTS_IN_USE, 11'd4));
      plan_q.push_back(req_row(rrs_pkg::OP_SEND, 11'd200, 16'hFFFF));
      // An empty ring, then a size above the slot count.
      plan_q.push_back(csr_row(rrs_pkg::CSR_SLOTS_IN_USE, 11'd0));
      plan_q.push_back(req_row(rrs_pkg::OP_SEND, 11'd200, 16'hFFFF));
      plan_q.push_back(csr_row(rrs_pkg::CSR_SLOTS_IN_USE, 11'd31));
      plan_q.push_back(req_row(rrs_pkg::OP_SEND, 11'd200, 16'h8000));
      // A flush is refused once the layout is withdrawn.
      plan_q.push_back(csr_row(rrs_pkg::CSR_BLOCK_READY, 11'd0));
      plan_q.push_back(req_row(rrs_pkg::OP_FLUSH, 11'd0, 16'h0000));

      for (k = 0; k < plan_q.size(); k++) begin
         row = plan_q[k];
         if (row.kind == ROW_CSR) write_csr(row.csr_idx, row.csr_data);
         else push_request(row.op, row.len, row.mask, row.typed, row.answer);
      end

      // Random phases. Each one sets a layout and an idling pattern: none, a slow
      // sender, a slow receiver, or both a little slow. Layouts that refuse every
      // send get short phases.
      for (phase = 0; phase < 16; phase++) begin
         ready_cfg = (phase != 7);
         case (phase)
            0: slots_cfg = 16;
            1: slots_cfg = 1;
            2: slots_cfg = 0;
            3: slots_cfg = 31;
            4: slots_cfg = 2;
            default: slots_cfg = ($urandom_range(4) == 0) ? $urandom_range(31, 17)
                                                          : $urandom_range(16, 3);
         endcase
         case (phase % 5)
            0: cap_cfg = 2047;
            1: cap_cfg = 14;
            2: cap_cfg = 1536;
            3: cap_cfg = $urandom_range(2047, 14);
            default: cap_cfg = $urandom_range(1517, 15);
         endcase
         if (phase == 9) cap_cfg = 0;
         n_items = (phase == 2 || phase == 7 || phase == 9) ? 30 : 133;

         write_csr(rrs_pkg::CSR_BLOCK_READY, 11'(ready_cfg));
         write_csr(rrs_pkg::CSR_SLOTS_IN_USE, 11'(slots_cfg));
         write_csr(rrs_pkg::CSR_SLOT_CAPACITY, 11'(cap_cfg));

         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 65;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 65;
            end
            default: begin
               send_idle_pct = 19;
               rsp_stall_pct = 19;
            end
         endcase

         lim = (cap_cfg < MAX_FRAME) ? cap_cfg : MAX_FRAME;
         for (item = 0; item < n_items; item++) begin
            k = $urandom_range(99);
            op = rrs_pkg::OP_SEND;
            if (k < 8) begin
               // Flush on demand, with random content in the ignored fields.
               op   = rrs_pkg::OP_FLUSH;
               len  = 11'($urandom);
               mask = 16'($urandom);
            end else if (k < 16) begin
               // A length on either side of the legal window.
               if ($urandom_range(1)) len = 11'($urandom_range(13));
               else len = 11'($urandom_range(2047, lim + 1));
               mask = 16'($urandom);
            end else begin
               // Mostly well-formed sends, so that batches fill and submit.
               if (lim >= rrs_pkg::MIN_FRAME) len = 11'($urandom_range(lim, rrs_pkg::MIN_FRAME));
               else len = 11'($urandom_range(2047));
               case ($urandom_range(9))
                  0: mask = '0;
                  1: mask = '1;
                  2: mask = 16'h1 << $urandom_range(15);
                  3, 4: mask = 16'($urandom & $urandom);
                  default: mask = 16'($urandom);
               endcase
            end
            push_request(op, len, mask, 1'b0, '0);
         end
      end

      // Drain the owed responses, then leave a few cycles for a stray one to show up.
      req_valid     = 1'b0;
      rsp_stall_pct = 0;
      while (grant_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
